FILE: sv/sha_pkg.sv
// Package: shared types, widths and codes for the hour/day averager.
package sha_pkg;

  localparam int EPOCH_W = 32;
  localparam int TEMP_W  = 15;
  localparam int HUM_W   = 14;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 16;
  localparam int WIN_W   = 6;
  localparam int REQ_W   = 2;
  localparam int HLEN_W  = 16;
  localparam int DLEN_W  = 20;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [HLEN_W-1:0] HLEN_RESET = 16'd3600;
  localparam logic [DLEN_W-1:0] DLEN_RESET = 20'd86400;

  localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_HOUR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DAY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HOUR_SECONDS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DAY_SECONDS  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_HMOD, S_DMOD, S_EVAL, S_HT, S_HH, S_HPUSH,
    S_DT, S_DH, S_DPUSH, S_ADD, S_QRD, S_QT, S_QH, S_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SUM_W-1:0] quot;
    logic [SUM_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: sv/sha_if.sv
// Interfaces: input, result and configuration channels.
interface sha_in_if;
  logic                        valid;
  logic                        ready;
  logic [sha_pkg::REQ_W-1:0]   req_type;
  logic [sha_pkg::EPOCH_W-1:0] epoch;
  logic signed [sha_pkg::TEMP_W-1:0] temp_sample;
  logic [sha_pkg::HUM_W-1:0]   hum_sample;
  logic                        sample_valid;
  logic [sha_pkg::WIN_W-1:0]   window_hours;
  modport source (output valid, req_type, epoch, temp_sample, hum_sample, sample_valid,
                  window_hours, input ready);
  modport sink (input valid, req_type, epoch, temp_sample, hum_sample, sample_valid,
                window_hours, output ready);
endinterface

interface sha_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sha_pkg::TEMP_W-1:0] avg_temp;
  logic [sha_pkg::HUM_W-1:0]         avg_hum;
  logic                              avg_found;
  logic [sha_pkg::WIN_W-1:0]         entries_used;
  modport source (output valid, avg_temp, avg_hum, avg_found, entries_used, input ready);
  modport sink (input valid, avg_temp, avg_hum, avg_found, entries_used, output ready);
endinterface

interface sha_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sha_pkg::CFG_IDX_W-1:0]  idx;
  logic [sha_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

FILE: sv/sensor_hour_day_averager.sv
// Top level: hour/day time-bucket averager with hourly and daily ring memories.
// One item is taken at a time; in_ch.ready is high only while the sequencer idles.
// Every division and modulo runs on one shared radix-2 divider.
// A sample tick runs two bucket-start modulos, then the two hour-mean divisions
// when it closes an hour and the two day-mean divisions when it closes a day; a
// tick with epoch zero or an unknown request is dropped without leaving idle. A query
// walks the ring memory one entry per cycle and then, if it found entries, runs
// the two mean divisions. Configuration writes are taken at any time on cfg_ch
// (always ready) and are meant for idle periods. A result waits in an output
// register; a further query stalls only when that register is still full.
module sensor_hour_day_averager #(
  parameter int HOUR_SLOTS = 32,
  parameter int DAY_SLOTS  = 8
) (
  input logic clk,
  input logic rst_n,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch,
  sha_cfg_if.sink   cfg_ch
);
  localparam int TW = sha_pkg::TEMP_W;
  localparam int HW = sha_pkg::HUM_W;
  localparam int SW = sha_pkg::SUM_W;
  localparam int EW = TW + HW;
  localparam int HA = $clog2(HOUR_SLOTS);
  localparam int DA = $clog2(DAY_SLOTS);
  localparam int HC = $clog2(HOUR_SLOTS + 1);
  localparam int DC = $clog2(DAY_SLOTS + 1);
  localparam int C1 = (HC > DC) ? HC : DC;
  localparam int CW = (C1 > sha_pkg::WIN_W) ? C1 : sha_pkg::WIN_W;

  sha_pkg::state_t state_r, state_nxt;

  // configuration
  logic [sha_pkg::HLEN_W-1:0] hlen_r;
  logic [sha_pkg::DLEN_W-1:0] dlen_r;

  // captured input item
  logic [sha_pkg::EPOCH_W-1:0] epoch_r;
  logic signed [TW-1:0]        tsmp_r;
  logic [HW-1:0]               hsmp_r;
  logic                        sv_r;

  // bucket state
  logic [SW-1:0] cur_h_r, cur_d_r, hs_r, ds_r;
  logic [SW-1:0] hts_r, hhs_r, dts_r, dhs_r;
  logic [sha_pkg::CNT_W-1:0] hcnt_r, dcnt_r;
  logic dchg_r;

  // rings
  logic [EW-1:0] hour_mem [HOUR_SLOTS];
  logic [EW-1:0] day_mem  [DAY_SLOTS];
  logic [EW-1:0] hour_rd_r, day_rd_r;
  logic [HA-1:0] hhead_r, walk_h_r, hhead_new;
  logic [DA-1:0] dhead_r, walk_d_r, dhead_new;
  logic [HC-1:0] hfill_r;
  logic [DC-1:0] dfill_r;

  // mean results
  logic signed [TW-1:0] mt_r;
  logic [HW-1:0]        mh_r;

  // query walk
  logic          q_day_r, rd_vld_r, issue;
  logic [CW-1:0] lim_r, iss_r, win_ext, hfill_ext;
  logic [SW-1:0] qts_r, qhs_r;
  logic [EW-1:0] rd_word;

  // output register
  logic                 out_valid_r;
  logic signed [TW-1:0] out_t_r;
  logic [HW-1:0]        out_h_r;
  logic                 out_f_r;
  logic [sha_pkg::WIN_W-1:0] out_n_r;

  // divider
  sha_pkg::div_req_t div_req;
  sha_pkg::div_rsp_t div_rsp;
  logic              pend_r;
  logic              neg;
  logic [SW-1:0]     quot_s;

  logic in_acc, h_close, d_chg, out_load;

  sha_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign in_ch.ready  = (state_r == sha_pkg::S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign h_close = (cur_h_r != '0) && (hs_r != cur_h_r) && (hcnt_r != '0);
  assign d_chg   = (cur_d_r != '0) && (ds_r != cur_d_r);
  assign issue   = (state_r == sha_pkg::S_QRD) && (iss_r != lim_r);
  assign out_load = (state_r == sha_pkg::S_OUT) && (!out_valid_r || out_ch.ready);

  assign hhead_new = (hfill_r == '0) ? '0 :
                     (hhead_r == HA'(HOUR_SLOTS - 1)) ? '0 : HA'(hhead_r + 1'b1);
  assign dhead_new = (dfill_r == '0) ? '0 :
                     (dhead_r == DA'(DAY_SLOTS - 1)) ? '0 : DA'(dhead_r + 1'b1);

  assign win_ext   = CW'(in_ch.window_hours);
  assign hfill_ext = CW'(hfill_r);
  assign rd_word   = q_day_r ? day_rd_r : hour_rd_r;

  // Divider operand select: magnitude of signed sums, sign restored on the quotient.
  always_comb begin
    div_req.start    = pend_r;
    div_req.dividend = epoch_r;
    div_req.divisor  = {{(SW-1){1'b0}}, 1'b1};
    neg              = 1'b0;
    case (state_r)
      sha_pkg::S_HMOD: div_req.divisor = (hlen_r == '0) ? SW'(1) : SW'(hlen_r);
      sha_pkg::S_DMOD: div_req.divisor = (dlen_r == '0) ? SW'(1) : SW'(dlen_r);
      sha_pkg::S_HT: begin
        neg              = hts_r[SW-1];
        div_req.dividend = neg ? SW'(-hts_r) : hts_r;
        div_req.divisor  = SW'(hcnt_r);
      end
      sha_pkg::S_HH: begin
        div_req.dividend = hhs_r;
        div_req.divisor  = SW'(hcnt_r);
      end
      sha_pkg::S_DT: begin
        neg              = dts_r[SW-1];
        div_req.dividend = neg ? SW'(-dts_r) : dts_r;
        div_req.divisor  = SW'(dcnt_r);
      end
      sha_pkg::S_DH: begin
        div_req.dividend = dhs_r;
        div_req.divisor  = SW'(dcnt_r);
      end
      sha_pkg::S_QT: begin
        neg              = qts_r[SW-1];
        div_req.dividend = neg ? SW'(-qts_r) : qts_r;
        div_req.divisor  = SW'(lim_r);
      end
      sha_pkg::S_QH: begin
        div_req.dividend = qhs_r;
        div_req.divisor  = SW'(lim_r);
      end
      default: ;
    endcase
    quot_s = neg ? SW'(-div_rsp.quot) : div_rsp.quot;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_ch.req_type)
            sha_pkg::REQ_TICK: if (in_ch.epoch != '0) state_nxt = sha_pkg::S_HMOD;
            sha_pkg::REQ_HOUR: state_nxt = sha_pkg::S_QRD;
            sha_pkg::REQ_DAY:  state_nxt = sha_pkg::S_QRD;
            default: ;
          endcase
        end
      end
      sha_pkg::S_HMOD: if (div_rsp.done) state_nxt = sha_pkg::S_DMOD;
      sha_pkg::S_DMOD: if (div_rsp.done) state_nxt = sha_pkg::S_EVAL;
      sha_pkg::S_EVAL: begin
        if (h_close) state_nxt = sha_pkg::S_HT;
        else if (d_chg && dcnt_r != '0) state_nxt = sha_pkg::S_DT;
        else state_nxt = sha_pkg::S_ADD;
      end
      sha_pkg::S_HT:    if (div_rsp.done) state_nxt = sha_pkg::S_HH;
      sha_pkg::S_HH:    if (div_rsp.done) state_nxt = sha_pkg::S_HPUSH;
      // a closed hour always leaves the day count nonzero
      sha_pkg::S_HPUSH: state_nxt = dchg_r ? sha_pkg::S_DT : sha_pkg::S_ADD;
      sha_pkg::S_DT:    if (div_rsp.done) state_nxt = sha_pkg::S_DH;
      sha_pkg::S_DH:    if (div_rsp.done) state_nxt = sha_pkg::S_DPUSH;
      sha_pkg::S_DPUSH: state_nxt = sha_pkg::S_ADD;
      sha_pkg::S_ADD:   state_nxt = sha_pkg::S_IDLE;
      sha_pkg::S_QRD: begin
        if (iss_r == lim_r && !rd_vld_r)
          state_nxt = (lim_r != '0) ? sha_pkg::S_QT : sha_pkg::S_OUT;
      end
      sha_pkg::S_QT:  if (div_rsp.done) state_nxt = sha_pkg::S_QH;
      sha_pkg::S_QH:  if (div_rsp.done) state_nxt = sha_pkg::S_OUT;
      sha_pkg::S_OUT: if (out_load) state_nxt = sha_pkg::S_IDLE;
      default: state_nxt = sha_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // start the divider only on entry to a division stage
      case (state_nxt)
        sha_pkg::S_HMOD, sha_pkg::S_DMOD, sha_pkg::S_HT, sha_pkg::S_HH,
        sha_pkg::S_DT, sha_pkg::S_DH, sha_pkg::S_QT, sha_pkg::S_QH:
          pend_r <= (state_nxt != state_r);
        default: pend_r <= 1'b0;
      endcase
    end
  end

  // Ring memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (state_r == sha_pkg::S_HPUSH) hour_mem[hhead_new] <= {mt_r, mh_r};
    hour_rd_r <= hour_mem[walk_h_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == sha_pkg::S_DPUSH) day_mem[dhead_new] <= {mt_r, mh_r};
    day_rd_r <= day_mem[walk_d_r];
  end

  // Payload captures and walk addresses
  always_ff @(posedge clk) begin
    if (in_acc) begin
      epoch_r  <= in_ch.epoch;
      tsmp_r   <= in_ch.temp_sample;
      hsmp_r   <= in_ch.hum_sample;
      sv_r     <= in_ch.sample_valid;
      q_day_r  <= (in_ch.req_type == sha_pkg::REQ_DAY);
      walk_h_r <= hhead_r;
      walk_d_r <= dhead_r;
      lim_r    <= (in_ch.req_type == sha_pkg::REQ_DAY) ? CW'(dfill_r) :
                  (win_ext < hfill_ext) ? win_ext : hfill_ext;
      iss_r    <= '0;
      qts_r    <= '0;
      qhs_r    <= '0;
    end
    if (div_rsp.done) begin
      case (state_r)
        sha_pkg::S_HMOD: hs_r <= epoch_r - div_rsp.rem;
        sha_pkg::S_DMOD: ds_r <= epoch_r - div_rsp.rem;
        sha_pkg::S_HT, sha_pkg::S_DT, sha_pkg::S_QT: mt_r <= quot_s[TW-1:0];
        sha_pkg::S_HH, sha_pkg::S_DH, sha_pkg::S_QH: mh_r <= div_rsp.quot[HW-1:0];
        default: ;
      endcase
    end
    if (state_r == sha_pkg::S_EVAL) dchg_r <= d_chg;
    // walk from the newest entry backward
    if (issue) begin
      iss_r    <= iss_r + 1'b1;
      walk_h_r <= (walk_h_r == '0) ? HA'(HOUR_SLOTS - 1) : HA'(walk_h_r - 1'b1);
      walk_d_r <= (walk_d_r == '0) ? DA'(DAY_SLOTS - 1) : DA'(walk_d_r - 1'b1);
    end
    if (rd_vld_r) begin
      qts_r <= qts_r + SW'(signed'(rd_word[EW-1:HW]));
      qhs_r <= qhs_r + SW'(rd_word[HW-1:0]);
    end
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hlen_r      <= sha_pkg::HLEN_RESET;
      dlen_r      <= sha_pkg::DLEN_RESET;
      cur_h_r     <= '0;
      cur_d_r     <= '0;
      hts_r       <= '0;
      hhs_r       <= '0;
      hcnt_r      <= '0;
      dts_r       <= '0;
      dhs_r       <= '0;
      dcnt_r      <= '0;
      hhead_r     <= '0;
      dhead_r     <= '0;
      hfill_r     <= '0;
      dfill_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.idx)
          sha_pkg::REG_HOUR_SECONDS: hlen_r <= cfg_ch.data[sha_pkg::HLEN_W-1:0];
          sha_pkg::REG_DAY_SECONDS:  dlen_r <= cfg_ch.data;
          default: ;
        endcase
      end
      rd_vld_r <= issue;
      case (state_r)
        sha_pkg::S_EVAL: begin
          // adopt the new starts; a zero start simply gets set
          cur_h_r <= hs_r;
          cur_d_r <= ds_r;
        end
        sha_pkg::S_HPUSH: begin
          hhead_r <= hhead_new;
          if (hfill_r != HC'(HOUR_SLOTS)) hfill_r <= hfill_r + 1'b1;
          if (dcnt_r != sha_pkg::CNT_MAX) begin
            dts_r  <= dts_r + SW'(mt_r);
            dhs_r  <= dhs_r + SW'(mh_r);
            dcnt_r <= dcnt_r + 1'b1;
          end
          hts_r  <= '0;
          hhs_r  <= '0;
          hcnt_r <= '0;
        end
        sha_pkg::S_DPUSH: begin
          dhead_r <= dhead_new;
          if (dfill_r != DC'(DAY_SLOTS)) dfill_r <= dfill_r + 1'b1;
          dts_r  <= '0;
          dhs_r  <= '0;
          dcnt_r <= '0;
        end
        sha_pkg::S_ADD: begin
          if (sv_r && hcnt_r != sha_pkg::CNT_MAX) begin
            hts_r  <= hts_r + SW'(tsmp_r);
            hhs_r  <= hhs_r + SW'(hsmp_r);
            hcnt_r <= hcnt_r + 1'b1;
          end
        end
        default: ;
      endcase
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Result register: an empty walk answers all zeros
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_f_r <= (lim_r != '0);
      out_t_r <= (lim_r != '0) ? mt_r : '0;
      out_h_r <= (lim_r != '0) ? mh_r : '0;
      out_n_r <= lim_r[sha_pkg::WIN_W-1:0];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.avg_temp     = out_t_r;
  assign out_ch.avg_hum      = out_h_r;
  assign out_ch.avg_found    = out_f_r;
  assign out_ch.entries_used = out_n_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hfill_r <= HC'(HOUR_SLOTS) && dfill_r <= DC'(DAY_SLOTS))
    else $error("ring fill count above ring depth");

  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha_pkg::S_HPUSH |=> hfill_r != '0 && dcnt_r != '0)
    else $error("hour push left ring or day count empty");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == sha_pkg::S_OUT)
    else $error("result raised outside of result stage");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> (state_r == sha_pkg::S_HMOD || state_r == sha_pkg::S_DMOD ||
      state_r == sha_pkg::S_HT || state_r == sha_pkg::S_HH || state_r == sha_pkg::S_DT ||
      state_r == sha_pkg::S_DH || state_r == sha_pkg::S_QT || state_r == sha_pkg::S_QH))
    else $error("divider busy outside a division stage");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha_pkg::S_QRD |-> iss_r <= lim_r)
    else $error("ring walk issued past its limit");

endmodule

FILE: sv/sha_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module sha_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::div_req_t req,
  output sha_pkg::div_rsp_t rsp
);
  localparam int W  = sha_pkg::SUM_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  quot_r, rem_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    trial;
  logic          fit;

  assign trial = {rem_r, quot_r[W-1]};
  assign fit   = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.dividend;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
    end else if (busy_r) begin
      rem_r  <= fit ? W'(trial - {1'b0, dvs_r}) : trial[W-1:0];
      quot_r <= {quot_r[W-2:0], fit};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;
endmodule
